/* rtl/core/integer_alu_with_sign_extend_macros.svh */
// assertion macros used by the integer alu top module
`ifndef INTEGER_ALU_WITH_SIGN_EXTEND_MACROS_SVH
`define INTEGER_ALU_WITH_SIGN_EXTEND_MACROS_SVH

// same-cycle implication, checked out of reset
`define IALU_ASSERT_SAME(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("ialu assertion failed");

// next-cycle implication, checked out of reset
`define IALU_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("ialu assertion failed");

`endif

/* rtl/core/ialu_pkg.sv */
// types, constants and helpers for the integer alu
package ialu_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int FUNC_W     = 4;
    localparam int SHAMT_W    = $clog2(WORD_WIDTH);
    localparam int SMEAR_STEPS = $clog2(WORD_WIDTH);

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [FIELD_W-1:0]    t_field;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_AND  = 4'd2,
        FN_OR   = 4'd3,
        FN_NOT  = 4'd4,
        FN_XOR  = 4'd5,
        FN_EQ   = 4'd6,
        FN_NEQ  = 4'd7,
        FN_LT   = 4'd8,
        FN_LTU  = 4'd9,
        FN_GE   = 4'd10,
        FN_GEU  = 4'd11,
        FN_SLL  = 4'd12,
        FN_SRL  = 4'd13,
        FN_SRA  = 4'd14,
        FN_SXT  = 4'd15
    } t_func;

    // one request as it sits in the input register
    typedef struct packed {
        t_func func;
        t_word a;
        t_word b;
    } t_alu_req;

    // zero-extend or cut a port field to the word width
    function automatic t_word to_word(input t_field v);
        t_word w;
        w = '0;
        for (int i = 0; i < WORD_WIDTH && i < FIELD_W; i++) begin
            w[i] = v[i];
        end
        return w;
    endfunction

    // low field bits of a word, zero-filled when the word is narrower
    function automatic t_field from_word(input t_word w);
        t_field v;
        v = '0;
        for (int i = 0; i < WORD_WIDTH && i < FIELD_W; i++) begin
            v[i] = w[i];
        end
        return v;
    endfunction

endpackage

/* rtl/core/ialu_shift.sv */
// barrel shifter for sll, srl and sra
module ialu_shift
    import ialu_pkg::*;
(
    input  t_alu_req i_req,
    output t_word    o_result
);

    logic               w_large;
    logic [SHAMT_W-1:0] w_shamt;
    logic               w_neg;

    // amounts of a full word or more flush the word
    assign w_large = (i_req.b >= t_word'(WORD_WIDTH));
    assign w_shamt = i_req.b[SHAMT_W-1:0];
    assign w_neg   = i_req.a[WORD_WIDTH-1];

    always_comb begin
        o_result = '0;
        case (i_req.func)
            FN_SLL: begin
                o_result = w_large ? '0 : (i_req.a << w_shamt);
            end
            FN_SRL: begin
                o_result = w_large ? '0 : (i_req.a >> w_shamt);
            end
            FN_SRA: begin
                if (w_large) begin
                    o_result = {WORD_WIDTH{w_neg}};
                end else begin
                    o_result = t_word'($signed(i_req.a) >>> w_shamt);
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

/* rtl/core/ialu_exec.sv */
// execute logic: arithmetic, logic, compares, sign extend, shift select
module ialu_exec
    import ialu_pkg::*;
(
    input  t_alu_req i_req,
    output t_word    o_result
);

    t_word w_shift;
    t_word w_smear;
    t_word w_upper;
    t_word w_sxt;
    logic  w_sign;

    ialu_shift u_shift (
        .i_req    (i_req),
        .o_result (w_shift)
    );

    // smear b's top set bit downward, giving ones at and below it
    always_comb begin
        w_smear = i_req.b;
        for (int k = 0; k < SMEAR_STEPS; k++) begin
            w_smear = w_smear | (w_smear >> (1 << k));
        end
    end

    // ones at and above the sign position
    assign w_upper = ~(w_smear >> 1);
    assign w_sign  = |(i_req.a & w_smear & w_upper);

    always_comb begin
        if (i_req.b == '0) begin
            w_sxt = i_req.a;
        end else if (w_sign) begin
            w_sxt = i_req.a | w_upper;
        end else begin
            w_sxt = i_req.a & ~w_upper;
        end
    end

    always_comb begin
        o_result = '0;
        case (i_req.func)
            FN_ADD:  o_result = i_req.a + i_req.b;
            FN_SUB:  o_result = i_req.a - i_req.b;
            FN_AND:  o_result = i_req.a & i_req.b;
            FN_OR:   o_result = i_req.a | i_req.b;
            FN_NOT:  o_result = ~i_req.b;
            FN_XOR:  o_result = i_req.a ^ i_req.b;
            FN_EQ:   o_result = t_word'(i_req.a == i_req.b);
            FN_NEQ:  o_result = t_word'(i_req.a != i_req.b);
            FN_LT:   o_result = t_word'($signed(i_req.a) < $signed(i_req.b));
            FN_LTU:  o_result = t_word'(i_req.a < i_req.b);
            FN_GE:   o_result = t_word'($signed(i_req.a) >= $signed(i_req.b));
            FN_GEU:  o_result = t_word'(i_req.a >= i_req.b);
            FN_SLL, FN_SRL, FN_SRA: begin
                o_result = w_shift;
            end
            FN_SXT:  o_result = w_sxt;
            default: o_result = '0;
        endcase
    end

endmodule

/* rtl/core/integer_alu_with_sign_extend.sv */
// path: input register, then result register, from an accepted request to o_valid
// throughput: one request per cycle unless o_stall is high, set by the single-pass
// execute logic between the input register and the result register
// stall: the input register keeps accepting while a result waits, holding one more
// reset: synchronous active-low i_rst_n clears both valid flags; no pending results
`include "integer_alu_with_sign_extend_macros.svh"

module integer_alu_with_sign_extend
    import ialu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [FIELD_W-1:0] i_operand_a,
    input  logic [FIELD_W-1:0] i_operand_b,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [FIELD_W-1:0] o_alu_result
);

    // input register stage
    logic     r_in_valid;
    logic     n_in_valid;
    t_alu_req r_req;

    // result register stage
    logic         r_out_valid;
    logic         n_out_valid;
    logic [FIELD_W-1:0] r_result;

    // combinational execute result
    t_word w_result;

    // handshake controls
    logic w_out_ready;
    logic w_in_take;
    logic w_advance;

    ialu_exec u_exec (
        .i_req    (r_req),
        .o_result (w_result)
    );

    // result register can load when empty or being drained this cycle
    assign w_out_ready = !r_out_valid || !i_stall;
    // input register is free unless it holds a request that cannot move on
    assign o_stall     = r_in_valid && !w_out_ready;
    assign w_in_take   = i_valid && !o_stall;
    assign w_advance   = r_in_valid && w_out_ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (!o_stall) begin
            n_in_valid = i_valid;
        end
        if (w_out_ready) begin
            n_out_valid = r_in_valid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_req.func <= t_func'(i_func);
            r_req.a    <= to_word(i_operand_a);
            r_req.b    <= to_word(i_operand_b);
        end
        if (w_advance) begin
            r_result <= from_word(w_result);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_alu_result = r_result;

    // back-pressure only when a request is actually parked in the input stage
    `IALU_ASSERT_SAME(a_stall_needs_req, i_clk, i_rst_n, o_stall, r_in_valid)
    // a request moving on always shows up as a result next cycle
    `IALU_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, w_advance, r_out_valid)
    // the result register captures the execute output of the moving request
    `IALU_ASSERT_NEXT(a_result_captured, i_clk, i_rst_n, w_advance,
        r_result == $past(from_word(w_result)))
    // a parked request survives while the output is blocked
    `IALU_ASSERT_NEXT(a_parked_kept, i_clk, i_rst_n,
        r_in_valid && r_out_valid && i_stall, r_in_valid && r_out_valid)

endmodule

/* tb/testbench.sv */
// testbench for the integer alu with sign extend: predicted results, random traffic and stalls
`timescale 1ns / 100ps

module testbench;
    import ialu_pkg::*;

    // one accepted request and the result it must produce
    typedef struct {
        t_func  func;
        t_field a;
        t_field b;
        t_field result;
    } t_pending;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    t_func  i_func = FN_ADD;
    t_field i_operand_a = '0;
    t_field i_operand_b = '0;
    logic   o_valid;
    logic   i_stall = 1'b0;
    t_field o_alu_result;

    // results still owed by the block, oldest first
    t_pending pending_results[$];
    int       mismatch_count = 0;

    // knobs the tests turn: random gaps on the sender, random stalls on the receiver
    bit tx_gaps_on = 1'b0;
    bit rx_stalls_on = 1'b0;
    // a test bumps this to ask the receiver for one long hold-off
    int hold_off_asked = 0;

    integer_alu_with_sign_extend DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_alu_result (o_alu_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // expected result word of one request, computed at the word width
    // and then cut or zero-filled to the port width
    function automatic t_field alu_result_of(input t_func fn, input t_field a_in,
                                             input t_field b_in);
        t_word                        a, b, r, upper;
        logic signed [WORD_WIDTH-1:0] sa, sb;
        int                           top;
        a = t_word'(a_in);
        b = t_word'(b_in);
        sa = a;
        sb = b;
        r = '0;
        case (fn)
            FN_ADD: r = a + b;
            FN_SUB: r = a - b;
            FN_AND: r = a & b;
            FN_OR:  r = a | b;
            FN_NOT: r = ~b;
            FN_XOR: r = a ^ b;
            FN_EQ:  r = t_word'(a == b);
            FN_NEQ: r = t_word'(a != b);
            FN_LT:  r = t_word'(sa < sb);
            FN_LTU: r = t_word'(a < b);
            FN_GE:  r = t_word'(sa >= sb);
            FN_GEU: r = t_word'(a >= b);
            FN_SLL: begin
                if (b >= WORD_WIDTH) r = '0;
                else r = a << b;
            end
            FN_SRL: begin
                if (b >= WORD_WIDTH) r = '0;
                else r = a >> b;
            end
            FN_SRA: begin
                // oversized amount leaves only copies of the sign bit
                if (b >= WORD_WIDTH) r = {WORD_WIDTH{a[WORD_WIDTH-1]}};
                else r = sa >>> b;
            end
            FN_SXT: begin
                // a zero mask passes a through untouched
                if (b == '0) begin
                    r = a;
                end else begin
                    top = 0;
                    for (int i = 0; i < WORD_WIDTH; i++) begin
                        if (b[i]) top = i;
                    end
                    // everything from the highest mask bit upward copies a at that bit
                    upper = ~t_word'(0) << top;
                    r = a[top] ? (a | upper) : (a & ~upper);
                end
            end
            default: r = '0;
        endcase
        return t_field'(r);
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // operand word leaning on the corners of the range
    function automatic t_field any_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return t_field'(1) << (FIELD_W - 1);
            3: return ~(t_field'(1) << (FIELD_W - 1));
            4: return t_field'(1) << $urandom_range(0, FIELD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // drop valid for a while, with junk on the payload meanwhile
    task automatic idle_between(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) begin
                i_func      <= t_func'($urandom_range(0, (1 << FUNC_W) - 1));
                i_operand_a <= $urandom;
                i_operand_b <= $urandom;
                @(posedge i_clk);
            end
        end
    endtask

    // offer one request and hold it until the block takes it; called right after an edge
    task automatic send_request(input t_func fn, input t_field a, input t_field b);
        if (tx_gaps_on) idle_between(gap_length());
        i_valid     <= 1'b1;
        i_func      <= fn;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back('{fn, a, b, alu_result_of(fn, a, b)});
    endtask

    // random request, with operand b shaped to hit the interesting cases of each operation
    task automatic send_random_request();
        t_func  fn;
        t_field a, b;
        int     pick;
        fn = t_func'($urandom_range(0, (1 << FUNC_W) - 1));
        a = any_operand();
        pick = $urandom_range(0, 9);
        case (fn)
            FN_SLL, FN_SRL, FN_SRA: begin
                // mostly in-range amounts, some just past the word width
                if (pick < 6) b = $urandom_range(0, WORD_WIDTH - 1);
                else if (pick < 8) b = $urandom_range(WORD_WIDTH, WORD_WIDTH + 8);
                else b = any_operand();
            end
            FN_SXT: begin
                // zero mask, one-hot masks and masks with low fill
                if (pick < 2) b = '0;
                else if (pick < 5) b = t_field'(1) << $urandom_range(0, FIELD_W - 1);
                else if (pick < 7) b = $urandom >> $urandom_range(0, FIELD_W - 1);
                else b = any_operand();
            end
            FN_EQ, FN_NEQ, FN_LT, FN_LTU, FN_GE, FN_GEU: begin
                // equal and neighboring operands make the compares flip
                if (pick < 4) b = a;
                else if (pick < 5) b = a + 1'b1;
                else if (pick < 6) b = a - 1'b1;
                else b = any_operand();
            end
            default: b = any_operand();
        endcase
        send_request(fn, a, b);
    endtask

    // sender stops and waits until every owed result is out
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    int hold_off_seen = 0;
    int hold_left = 0;
    int rx_stall_left = 0;
    int rx_run_left = 0;
    always @(posedge i_clk) begin
        if (hold_off_asked != hold_off_seen) begin
            hold_left = 60;
            hold_off_seen = hold_off_asked;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_stalls_on) begin
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_stall <= 1'b1;
            end else if (rx_run_left > 0) begin
                rx_run_left--;
                i_stall <= 1'b0;
            end else begin
                rx_stall_left = gap_length();
                rx_run_left = $urandom_range(0, 8);
                i_stall <= 1'b0;
            end
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result checker: every result taken is matched against the oldest owed one
    t_pending owed;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result %h with no request outstanding", $time, o_alu_result);
                mismatch_count++;
            end else begin
                owed = pending_results.pop_front();
                if (o_alu_result !== owed.result) begin
                    $display("%0t: %s a=%h b=%h: expected %h, got %h", $time,
                             owed.func.name(), owed.a, owed.b, owed.result, o_alu_result);
                    mismatch_count++;
                end
            end
        end
    end

    // every operation at least once, the field extremes and the corner cases of shifts and extend
    task automatic test_directed();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        send_request(FN_ADD, 32'hFFFF_FFFF, 32'h0000_0001);   // wraps to zero
        send_request(FN_SUB, 32'h0000_0000, 32'h0000_0001);   // wraps to all ones
        send_request(FN_AND, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_request(FN_OR,  32'h0000_0000, 32'h0000_0000);
        send_request(FN_NOT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FN_XOR, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
        send_request(FN_EQ,  32'h8000_0000, 32'h8000_0000);
        send_request(FN_NEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // signed and unsigned order disagree across the sign bit
        send_request(FN_LT,  32'h8000_0000, 32'h7FFF_FFFF);
        send_request(FN_LTU, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(FN_GE,  32'h7FFF_FFFF, 32'h8000_0000);
        send_request(FN_GEU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FN_SLL, 32'hFFFF_FFFF, 32'd31);
        // amounts at or past the word width, plus one in-range arithmetic shift
        send_request(FN_SLL, 32'hFFFF_FFFF, 32'd32);
        send_request(FN_SRL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FN_SRA, 32'h8000_0000, 32'd31);
        send_request(FN_SRA, 32'h8000_0001, 32'd32);
        send_request(FN_SRA, 32'h7FFF_FFFF, 32'd100);
        // sign extend: zero mask, lowest and highest positions, set and clear
        send_request(FN_SXT, 32'h1234_5678, 32'h0000_0000);
        send_request(FN_SXT, 32'h0000_0001, 32'h0000_0001);
        send_request(FN_SXT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(FN_SXT, 32'h0000_0100, 32'h0000_0180);
        send_request(FN_SXT, 32'hFFFF_FE00, 32'h0000_0180);
        wait_for_drain();
    endtask

    // random requests with gaps on both sides
    task automatic test_random_traffic(input int count);
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        repeat (count) send_random_request();
        wait_for_drain();
    endtask

    // full rate in both directions, no idling at all
    task automatic test_back_to_back(input int count);
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (count) send_random_request();
        wait_for_drain();
    endtask

    // receiver holds off for a long stretch while requests keep coming,
    // so the block fills and stalls its input
    task automatic test_receiver_hold_off(input int count);
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        hold_off_asked++;
        repeat (count) send_random_request();
        wait_for_drain();
    endtask

    // sender pauses mid-stream until every result is back, then resumes
    task automatic test_drain_pause(input int count);
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        repeat (count / 3) send_random_request();
        wait_for_drain();
        idle_between($urandom_range(1, 20));
        repeat (count - count / 3) send_random_request();
        wait_for_drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic(220);
        test_back_to_back(100);
        test_receiver_hold_off(40);
        test_drain_pause(80);
        // let any stray result show up before the verdict
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS integer_alu_with_sign_extend");
        end else begin
            $display("FAIL integer_alu_with_sign_extend");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("FAIL integer_alu_with_sign_extend");
        $finish;
    end

endmodule
